// ===== hdl/polyline_curvature_stream_assert.svh =====
// assertion macros for the polyline curvature stream
`ifndef POLYLINE_CURVATURE_STREAM_ASSERT_SVH
`define POLYLINE_CURVATURE_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pcs_pkg.sv =====
`timescale 1ns / 1ps
package pcs_pkg;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_LONE     = 2'd2;

  // fraction bits kept by the square root
  localparam int SQRT_FRAC = 16;

  // job control travelling with each queued job
  typedef struct packed {
    logic lone;
    logic last;
  } pcs_ctl_t;

endpackage

// ===== hdl/pcs_front.sv =====
`timescale 1ns / 1ps
module pcs_front import pcs_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                px,
  input  logic [31:0]                py,
  input  logic                       end_of_line,
  output logic                       job_valid,
  input  logic                       job_ready,
  output logic [4*COORD_WIDTH+7:0]   job_data,
  output pcs_ctl_t                   job_ctl
);

  localparam int W = COORD_WIDTH;
  localparam int D = W + 2;

  logic signed [W-1:0] cx, cy;
  logic signed [W-1:0] prev_x, prev_y, older_x, older_y;
  logic [1:0]          points_seen;
  logic                pend;
  logic [4*D-1:0]      pend_job;
  logic [4*D-1:0]      job1, job2;
  pcs_ctl_t            ctl1;
  logic                accept;

  // coordinate from the low W bits of the 32-bit field, zero-extended when W is wider
  generate
    if (W <= 32) begin : g_narrow
      assign cx = px[W-1:0];
      assign cy = py[W-1:0];
    end else begin : g_wide
      assign cx = {{(W-32){1'b0}}, px};
      assign cy = {{(W-32){1'b0}}, py};
    end
  endgenerate

  function automatic logic [D-1:0] ext(input logic signed [W-1:0] v);
    ext = {{2{v[W-1]}}, v};
  endfunction

  // differences {sy, sx, dy, dx}; exact in D bits since results fit
  function automatic logic [4*D-1:0] diffs(
    input logic [D-1:0] x0, input logic [D-1:0] y0,
    input logic [D-1:0] x1, input logic [D-1:0] y1,
    input logic [D-1:0] x2, input logic [D-1:0] y2);
    logic [D-1:0] dx, dy, sx, sy;
    dx = x2 - x0;
    dy = y2 - y0;
    sx = x0 - (x1 << 1) + x2;
    sy = y0 - (y1 << 1) + y2;
    diffs = {sy, sx, dy, dx};
  endfunction

  // job for the point before the incoming one
  always_comb begin
    if (points_seen == 2'd1) begin
      job1 = diffs(ext(cx), (ext(prev_y) << 1) - ext(cy), ext(prev_x), ext(prev_y),
                   ext(cx), ext(cy));
    end else begin
      job1 = diffs(ext(older_x), ext(older_y), ext(prev_x), ext(prev_y),
                   ext(cx), ext(cy));
    end
    ctl1.lone = (points_seen == 2'd0);
    ctl1.last = (points_seen == 2'd0);
  end

  // job for the final point of a line
  assign job2 = diffs(ext(prev_x), ext(prev_y), ext(cx), ext(cy),
                      ext(prev_x), (ext(cy) << 1) - ext(prev_y));

  assign in_ready  = !pend && job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = pend || (in_valid && ((points_seen != 2'd0) || end_of_line));
  assign job_data  = pend ? pend_job : job1;
  assign job_ctl   = pend ? pcs_ctl_t'{lone: 1'b0, last: 1'b1} : ctl1;

  // point history and second-job holding
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      pend        <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
      older_x     <= '0;
      older_y     <= '0;
    end else begin
      if (pend && job_ready) begin
        pend <= 1'b0;
      end
      if (accept) begin
        if (points_seen == 2'd0) begin
          if (!end_of_line) begin
            prev_x      <= cx;
            prev_y      <= cy;
            points_seen <= 2'd1;
          end
        end else if (end_of_line) begin
          pend        <= 1'b1;
          pend_job    <= job2;
          points_seen <= 2'd0;
        end else begin
          older_x     <= prev_x;
          older_y     <= prev_y;
          prev_x      <= cx;
          prev_y      <= cy;
          points_seen <= 2'd2;
        end
      end
    end
  end

endmodule

// ===== hdl/pcs_queue.sv =====
`timescale 1ns / 1ps
module pcs_queue import pcs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wp, rp;
  logic [1:0]       count;
  logic             push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/pcs_back.sv =====
`timescale 1ns / 1ps
module pcs_back import pcs_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_valid,
  output logic                     job_ready,
  input  logic [4*COORD_WIDTH+7:0] job_data,
  input  pcs_ctl_t                 job_ctl,
  output logic                     m_valid,
  input  logic                     m_ready,
  output logic [31:0]              curvature,
  output logic [1:0]               status,
  output logic                     last_result
);

  localparam int W    = COORD_WIDTH;
  localparam int D    = W + 2;
  localparam int MW   = D;
  localparam int CW   = 2 * W + 4;
  localparam int SW   = (CW + 2 * SQRT_FRAC + 1) / 2;
  localparam int RADW = 2 * SW;
  localparam int DENW = CW + SW;
  localparam int NW   = CW + 2 + 2 * FRAC_BITS + SQRT_FRAC;
  localparam int CNTW = $clog2(NW);

  localparam logic [1:0] PH_P1 = 2'd0;
  localparam logic [1:0] PH_P2 = 2'd1;
  localparam logic [1:0] PH_DX = 2'd2;
  localparam logic [1:0] PH_DY = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_NUM  = 7'b0000100,
    S_SQRT = 7'b0001000,
    S_DEN  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t            state;
  logic [1:0]        ph;
  logic [CNTW-1:0]   cnt;
  logic [MW-1:0]     adx, ady, asx, asy;
  logic              n1, n2, neg, big;
  logic [CW-1:0]     p1, p2, c, nmag;
  logic [DENW-1:0]   acc, mc, acc_next, den, drem, drem_next;
  logic [SW-1:0]     mp, root, root_next;
  logic [RADW-1:0]   rad;
  logic [SW+1:0]     srem, srem_next, trial;
  logic [SW+3:0]     rem2, sq_sub;
  logic              sq_ge;
  logic [CW:0]       t1, t2, nsum, nabs;
  logic [NW-1:0]     num;
  logic [DENW:0]     r2, dsub;
  logic              dv_ge, big_next;
  logic [31:0]       q, q_next, lim, sat, curv;
  logic [31:0]       res_curv;
  logic [1:0]        res_st;
  logic              res_last;
  logic [D-1:0]      jdx, jdy, jsx, jsy;

  function automatic logic [MW-1:0] mag(input logic [D-1:0] v);
    mag = v[D-1] ? (~v + 1'b1) : v;
  endfunction

  assign jdx = job_data[D-1:0];
  assign jdy = job_data[2*D-1:D];
  assign jsx = job_data[3*D-1:2*D];
  assign jsy = job_data[4*D-1:3*D];

  assign job_ready = (state == S_IDLE);

  // shared shift-add multiplier step
  assign acc_next = acc + (mp[0] ? mc : '0);

  // signed numerator from the two product magnitudes
  always_comb begin
    t1   = n1 ? ((CW+1)'(0) - {1'b0, p1}) : {1'b0, p1};
    t2   = n2 ? ((CW+1)'(0) - {1'b0, p2}) : {1'b0, p2};
    nsum = t1 + t2;
    nabs = nsum[CW] ? ((CW+1)'(0) - nsum) : nsum;
  end

  // one root bit per cycle
  always_comb begin
    rem2      = {srem, rad[RADW-1 -: 2]};
    trial     = {root, 2'b01};
    sq_ge     = (rem2 >= {2'b00, trial});
    sq_sub    = rem2 - {2'b00, trial};
    srem_next = sq_ge ? sq_sub[SW+1:0] : rem2[SW+1:0];
    root_next = {root[SW-2:0], sq_ge};
  end

  // one quotient bit per cycle, overflow tracked past bit 31
  always_comb begin
    r2        = {drem, num[NW-1]};
    dv_ge     = (r2 >= {1'b0, den});
    dsub      = r2 - {1'b0, den};
    drem_next = dv_ge ? dsub[DENW-1:0] : r2[DENW-1:0];
    q_next    = {q[30:0], dv_ge};
    big_next  = big | q[31];
    lim       = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    sat       = (big_next || (q_next > lim)) ? lim : q_next;
    curv      = neg ? (32'd0 - sat) : sat;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      if (m_valid && m_ready && (state != S_DONE)) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            res_last <= job_ctl.last;
            if (job_ctl.lone) begin
              res_curv <= '0;
              res_st   <= ST_LONE;
              state    <= S_DONE;
            end else begin
              adx   <= mag(jdx);
              ady   <= mag(jdy);
              asx   <= mag(jsx);
              asy   <= mag(jsy);
              n1    <= jdx[D-1] ^ jsy[D-1];
              n2    <= ~(jsx[D-1] ^ jdy[D-1]);
              acc   <= '0;
              mc    <= DENW'(mag(jdx));
              mp    <= SW'(mag(jsy));
              cnt   <= CNTW'(MW - 1);
              ph    <= PH_P1;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            cnt <= CNTW'(MW - 1);
            case (ph)
              PH_P1: begin
                p1  <= acc_next[CW-1:0];
                acc <= '0;
                mc  <= DENW'(asx);
                mp  <= SW'(ady);
                ph  <= PH_P2;
              end
              PH_P2: begin
                p2  <= acc_next[CW-1:0];
                acc <= '0;
                mc  <= DENW'(adx);
                mp  <= SW'(adx);
                ph  <= PH_DX;
              end
              PH_DX: begin
                acc <= acc_next;
                mc  <= DENW'(ady);
                mp  <= SW'(ady);
                ph  <= PH_DY;
              end
              default: begin
                c     <= acc_next[CW-1:0];
                state <= S_NUM;
              end
            endcase
          end else begin
            acc <= acc_next;
            mc  <= mc << 1;
            mp  <= mp >> 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_NUM: begin
          neg  <= nsum[CW];
          nmag <= nabs[CW-1:0];
          if (c == '0) begin
            res_curv <= '0;
            res_st   <= ST_ZERO_DEN;
            state    <= S_DONE;
          end else begin
            rad   <= {{(RADW-CW){1'b0}}, c} << (2 * SQRT_FRAC);
            srem  <= '0;
            root  <= '0;
            cnt   <= CNTW'(SW - 1);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad  <= rad << 2;
          srem <= srem_next;
          root <= root_next;
          if (cnt == '0) begin
            acc   <= '0;
            mc    <= DENW'(c);
            mp    <= root_next;
            cnt   <= CNTW'(SW - 1);
            state <= S_DEN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DEN: begin
          acc <= acc_next;
          mc  <= mc << 1;
          mp  <= mp >> 1;
          if (cnt == '0) begin
            den   <= acc_next;
            num   <= {nmag, {(NW-CW){1'b0}}};
            drem  <= '0;
            q     <= '0;
            big   <= 1'b0;
            cnt   <= CNTW'(NW - 1);
            state <= S_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          num  <= num << 1;
          drem <= drem_next;
          q    <= q_next;
          big  <= big_next;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            res_curv <= curv;
            res_st   <= ST_OK;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_valid || m_ready) begin
            m_valid     <= 1'b1;
            curvature   <= res_curv;
            status      <= res_st;
            last_result <= res_last;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/polyline_curvature_stream.sv =====
`timescale 1ns / 1ps
// jobs run one at a time through a shared bit-serial multiply, root and divide unit, which
//   takes no new job from the queue until the last result is loaded into the output beat;
//   a final point that follows other points of its line yields two such jobs
// root width SW = W+18, dividend width NW = 2W+2F+22 (W coordinate width, F fraction bits)
// lone points skip the arithmetic, zero denominators skip the root and divide
// reset: synchronous, active high; clears point history, queue and output beat
`include "polyline_curvature_stream_assert.svh"
module polyline_curvature_stream import pcs_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // px [31:0], py [63:32]
  input  logic        s_tlast,   // end_of_line
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // curvature [31:0]
  output logic [1:0]  m_tuser,   // status [1:0]
  output logic        m_tlast    // last_result
);

  localparam int JW = 4 * (COORD_WIDTH + 2);

  logic          f_valid, f_ready, q_valid, q_ready;
  logic [JW-1:0] f_data, q_data;
  pcs_ctl_t      f_ctl, q_ctl;
  logic [JW+1:0] q_out;

  // point intake and job building
  pcs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .px          (s_tdata[31:0]),
    .py          (s_tdata[63:32]),
    .end_of_line (s_tlast),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job_data    (f_data),
    .job_ctl     (f_ctl)
  );

  // job queue between front and back
  pcs_queue #(.WIDTH(JW + 2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_ctl, f_data}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_out)
  );

  assign q_data = q_out[JW-1:0];
  assign q_ctl  = q_out[JW+1:JW];

  // curvature arithmetic and output beat
  pcs_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job_data    (q_data),
    .job_ctl     (q_ctl),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .curvature   (m_tdata),
    .status      (m_tuser),
    .last_result (m_tlast)
  );

  // checks
  `PCS_ASSERT_IMPLY(a_lone_beat, m_tvalid && m_tuser == ST_LONE, m_tdata == '0 && m_tlast, "bad lone beat")
  `PCS_ASSERT_IMPLY(a_zero_den, m_tvalid && m_tuser == ST_ZERO_DEN, m_tdata == '0, "zero den beat not zero")
  `PCS_ASSERT_IMPLY(a_lone_job, f_valid && f_ctl.lone, f_ctl.last, "lone job not marked final")
  `PCS_ASSERT_NEXT(a_back_busy, q_valid && q_ready, !q_ready, "back took a job but stayed idle")

endmodule
